FILE: rtl/u8l1_pkg.sv
// Shared types and constants for the UTF-8 to Latin-1 converter.
package u8l1_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CHAR_COUNT_W   = 16;
    localparam int ACC_W          = 31;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    localparam logic [7:0] LATIN_SPACE = 8'h20;

    typedef struct packed {
        logic [2:0]       remaining;
        logic [2:0]       seq_len;
        logic [ACC_W-1:0] acc;
        logic             stopped;
    } t_dec_state;

    typedef struct packed {
        logic has_res;
        logic inc_count;
        logic clr_count;
    } t_dec_ctrl;

    typedef struct packed {
        logic [7:0] latin_byte;
        logic       char_valid;
        logic       done_res;
        logic [1:0] status;
    } t_dec_res;

endpackage

FILE: rtl/u8l1_if.sv
// Valid/ready channel interfaces for the converter's byte input and result output.
interface u8l1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8l1_out_if;
    logic                               valid;
    logic                               ready;
    logic [7:0]                         latin_byte;
    logic                               char_valid;
    logic                               done_res;
    logic [1:0]                         status;
    logic [u8l1_pkg::CHAR_COUNT_W-1:0]  char_count;

    modport source (output valid, output latin_byte, output char_valid, output done_res,
                    output status, output char_count, input ready);
    modport sink   (input valid, input latin_byte, input char_valid, input done_res,
                    input status, input char_count, output ready);
endinterface

FILE: rtl/utf8_to_latin1_converter_unit.sv
// A byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle unless a held result waits on o_out.ready; each byte
// goes through one combinational decode pass between the input and result registers.
// Bytes that produce no result (mid-sequence, skipped after a stop) still take a decode pass.
// Reset (synchronous, i_rst_n low): clears sequence state, emitted count, mode and valids.
module utf8_to_latin1_converter_unit #(
    parameter int COUNT_BITS = u8l1_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    u8l1_in_if.sink           i_in,
    u8l1_out_if.source        o_out
);
    import u8l1_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    t_dec_state            r_state;
    t_dec_state            n_state;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic                  r_replace;
    logic                  r_out_valid;
    t_dec_res              r_out;
    logic [CHAR_COUNT_W-1:0] r_out_count;
    logic [CHAR_COUNT_W-1:0] n_shown;
    logic [31:0]           count_ext;

    t_dec_ctrl             dec_ctrl;
    t_dec_res              dec_res;
    logic                  advance;
    logic                  fire;

    assign advance     = !r_out_valid || o_out.ready;
    assign fire        = r_in_valid && advance;
    assign i_in.ready  = !r_in_valid || advance;

    u8l1_decode u_decode (
        .i_state      (r_state),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .i_replace    (r_replace),
        .o_next_state (n_state),
        .o_ctrl       (dec_ctrl),
        .o_res        (dec_res)
    );

    // count including this byte's character, shown saturated to the port width
    assign n_count   = (dec_ctrl.inc_count && r_count != COUNT_MAX) ?
                       r_count + COUNT_BITS'(1) : r_count;
    assign count_ext = 32'(n_count);
    assign n_shown   = (count_ext > 32'h0000FFFF) ? '1 : count_ext[CHAR_COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_count     <= '0;
            r_replace   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_replace <= i_cfg_wdata;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (fire) begin
                r_state     <= n_state;
                r_count     <= dec_ctrl.clr_count ? '0 : n_count;
                r_out_valid <= dec_ctrl.has_res;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
        if (fire && dec_ctrl.has_res) begin
            r_out       <= dec_res;
            r_out_count <= n_shown;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.latin_byte = r_out.latin_byte;
    assign o_out.char_valid = r_out.char_valid;
    assign o_out.done_res   = r_out.done_res;
    assign o_out.status     = r_out.status;
    assign o_out.char_count = r_out_count;

endmodule

FILE: rtl/u8l1_decode.sv
// Single-pass UTF-8 byte decoder: next sequence state and result for one byte.
module u8l1_decode (
    input  u8l1_pkg::t_dec_state i_state,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  logic                 i_replace,
    output u8l1_pkg::t_dec_state o_next_state,
    output u8l1_pkg::t_dec_ctrl  o_ctrl,
    output u8l1_pkg::t_dec_res   o_res
);
    import u8l1_pkg::*;

    logic [ACC_W-1:0] nv;
    logic [ACC_W-1:0] fin_v;
    logic [2:0]       fin_len;
    logic [2:0]       need_len;
    logic [2:0]       lead_len;
    logic [ACC_W-1:0] lead_v;
    logic             fin_bad;
    logic             fin_range;
    logic             do_stop;
    logic [1:0]       stop_code;
    logic             do_finish;

    assign nv = {i_state.acc[ACC_W-7:0], i_data_byte[5:0]};

    // character value and length when a character completes this byte
    assign fin_v   = (i_state.remaining == 3'd0) ? ACC_W'(i_data_byte) : nv;
    assign fin_len = (i_state.remaining == 3'd0) ? 3'd1 : i_state.seq_len;

    always_comb begin
        if (fin_v < ACC_W'(32'h80))            need_len = 3'd1;
        else if (fin_v < ACC_W'(32'h800))      need_len = 3'd2;
        else if (fin_v < ACC_W'(32'h10000))    need_len = 3'd3;
        else if (fin_v < ACC_W'(32'h200000))   need_len = 3'd4;
        else if (fin_v < ACC_W'(32'h4000000))  need_len = 3'd5;
        else                                   need_len = 3'd6;
    end

    assign fin_bad = (fin_len > 3'd1) &&
                     ((fin_v >= ACC_W'(32'hD800) && fin_v <= ACC_W'(32'hDFFF)) ||
                      fin_v == ACC_W'(32'hFFFE) || fin_v == ACC_W'(32'hFFFF) ||
                      need_len < fin_len);
    assign fin_range = (fin_v[ACC_W-1:8] != '0);

    always_comb begin
        if (i_data_byte < 8'hE0) begin
            lead_len = 3'd2; lead_v = ACC_W'(i_data_byte[4:0]);
        end else if (i_data_byte < 8'hF0) begin
            lead_len = 3'd3; lead_v = ACC_W'(i_data_byte[3:0]);
        end else if (i_data_byte < 8'hF8) begin
            lead_len = 3'd4; lead_v = ACC_W'(i_data_byte[2:0]);
        end else if (i_data_byte < 8'hFC) begin
            lead_len = 3'd5; lead_v = ACC_W'(i_data_byte[1:0]);
        end else begin
            lead_len = 3'd6; lead_v = ACC_W'(i_data_byte[0]);
        end
    end

    always_comb begin
        o_next_state = i_state;
        o_ctrl       = '0;
        o_res        = '0;
        do_stop      = 1'b0;
        stop_code    = ST_MALFORMED;
        do_finish    = 1'b0;

        if (i_state.stopped) begin
            // skip until the end of the string, which clears everything quietly
            if (i_last_byte) begin
                o_next_state     = '0;
                o_ctrl.clr_count = 1'b1;
            end
        end else if (i_state.remaining == 3'd0) begin
            if (i_data_byte < 8'h80) begin
                do_finish = 1'b1;
            end else if (i_data_byte <= 8'hBF || i_data_byte >= 8'hFE || i_last_byte) begin
                do_stop = 1'b1;
            end else begin
                o_next_state.remaining = lead_len - 3'd1;
                o_next_state.seq_len   = lead_len;
                o_next_state.acc       = lead_v;
            end
        end else begin
            if (i_data_byte[7:6] != 2'b10 || nv <= i_state.acc) begin
                do_stop = 1'b1;
            end else if (i_state.remaining == 3'd1) begin
                do_finish = 1'b1;
            end else if (i_last_byte) begin
                do_stop = 1'b1;
            end else begin
                o_next_state.remaining = i_state.remaining - 3'd1;
                o_next_state.acc       = nv;
            end
        end

        if (do_finish) begin
            if (fin_bad) begin
                do_stop = 1'b1;
            end else if (fin_range && !i_replace) begin
                do_stop   = 1'b1;
                stop_code = ST_RANGE;
            end else begin
                o_ctrl.has_res   = 1'b1;
                o_ctrl.inc_count = 1'b1;
                o_ctrl.clr_count = i_last_byte;
                o_res.latin_byte = fin_range ? LATIN_SPACE : fin_v[7:0];
                o_res.char_valid = 1'b1;
                o_res.done_res   = i_last_byte;
                o_res.status     = ST_OK;
                o_next_state     = '0;
            end
        end

        if (do_stop) begin
            o_ctrl.has_res   = 1'b1;
            o_ctrl.inc_count = 1'b0;
            o_ctrl.clr_count = i_last_byte;
            o_res.latin_byte = 8'h00;
            o_res.char_valid = 1'b0;
            o_res.done_res   = 1'b1;
            o_res.status     = stop_code;
            o_next_state     = '0;
            o_next_state.stopped = !i_last_byte;
        end
    end

endmodule
